/* rtl/quaternion_point_rotation_macros.svh */
// ----------------------------------------------------------------------------
// quaternion_point_rotation_macros
// assertion helpers shared by the rotation block
// ----------------------------------------------------------------------------
`ifndef QUATERNION_POINT_ROTATION_MACROS_SVH
`define QUATERNION_POINT_ROTATION_MACROS_SVH

// property must hold at every edge outside reset
`define QPR_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define QPR_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/qpr_pkg.sv */
// ----------------------------------------------------------------------------
// qpr_pkg
// shared widths, types and pipeline constants for quaternion point rotation
// ----------------------------------------------------------------------------
`default_nettype none

package qpr_pkg;

    localparam int QW       = 16;          // quaternion part width
    localparam int CW       = 32;          // coordinate width
    localparam int NUM_W    = 68;          // exact numerator width
    localparam int DEN_W    = 33;          // squared norm width
    localparam int LANES    = 3;
    localparam int DIV_STEPS = CW;         // one quotient bit per stage

    localparam logic [CW-1:0] POS_RAIL = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] NEG_RAIL = 32'h8000_0000;

    typedef logic signed [NUM_W-1:0] num_t;
    typedef logic [DEN_W-1:0]        den_t;
    typedef logic signed [CW-1:0]    coord_t;

    typedef struct packed {
        logic valid;
        logic zero;
    } qpr_ctl_t;

endpackage

`default_nettype wire

/* rtl/quaternion_point_rotation.sv */
// ----------------------------------------------------------------------------
// quaternion_point_rotation
// rotates a Q16.16 point by a Q1.14 quaternion, q p conj(q) / |q|^2
// ----------------------------------------------------------------------------
// channel   dir  tdata                                     tuser
// s_axis    in   q_w,q_x,q_y,q_z,point_x,point_y,point_z    -
// m_axis    out  rot_x,rot_y,rot_z                          zero_quat,saturated
//
// one item per cycle while results are taken
// the divider has a preparation stage and 32 bit-step stages, one quotient bit per stage
// four arithmetic stages ahead of it: products, sums, products, numerators
// whole pipeline holds while a result waits untaken; nothing is dropped
// reset clears the valid and zero control bits only
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_point_rotation (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // q_w, q_x, q_y, q_z, point_x, point_y, point_z
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // rot_x, rot_y, rot_z
    output logic [95:0]       m_tdata,
    // zero_quat, saturated
    output logic [1:0]        m_tuser
);
    import qpr_pkg::*;

    `include "quaternion_point_rotation_macros.svh"

    logic adv;

    logic signed [QW-1:0] q_w, q_x, q_y, q_z;
    logic signed [CW-1:0] p_x, p_y, p_z;

    // stage 1: elementary products
    logic                 v1_reg;
    logic signed [31:0]   ww1_reg, xx1_reg, yy1_reg, zz1_reg;
    logic signed [47:0]   xv1_reg, yv1_reg, zv1_reg;
    logic signed [47:0]   yvz1_reg, zvy1_reg, zvx1_reg, xvz1_reg, xvy1_reg, yvx1_reg;
    logic signed [QW-1:0] w1_reg, x1_reg, y1_reg, z1_reg;
    logic signed [CW-1:0] px1_reg, py1_reg, pz1_reg;

    // stage 2: norm and combined terms
    logic                 v2_reg;
    logic signed [33:0]   a2_reg;
    den_t                 n2_reg;
    logic signed [50:0]   d2_reg;
    logic signed [48:0]   cx2_reg, cy2_reg, cz2_reg;
    logic signed [16:0]   w2_reg;
    logic signed [QW-1:0] x2_reg, y2_reg, z2_reg;
    logic signed [CW-1:0] px2_reg, py2_reg, pz2_reg;

    // stage 3: wide products
    logic                 v3_reg;
    den_t                 n3_reg;
    num_t                 av3_reg [LANES];
    num_t                 du3_reg [LANES];
    num_t                 wc3_reg [LANES];

    // stage 4: numerators
    qpr_ctl_t             ctl4_reg;
    den_t                 n4_reg;
    num_t                 num4_reg [LANES];

    qpr_ctl_t             out_ctl;
    coord_t               rot [LANES];
    logic                 sat;

    assign {p_z, p_y, p_x, q_z, q_y, q_x, q_w} = s_tdata;

    assign adv      = !out_ctl.valid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            ctl4_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg         <= s_tvalid;
            v2_reg         <= v1_reg;
            v3_reg         <= v2_reg;
            ctl4_reg.valid <= v3_reg;
            ctl4_reg.zero  <= n3_reg == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ww1_reg  <= 32'(q_w) * 32'(q_w);
            xx1_reg  <= 32'(q_x) * 32'(q_x);
            yy1_reg  <= 32'(q_y) * 32'(q_y);
            zz1_reg  <= 32'(q_z) * 32'(q_z);
            xv1_reg  <= 48'(q_x) * 48'(p_x);
            yv1_reg  <= 48'(q_y) * 48'(p_y);
            zv1_reg  <= 48'(q_z) * 48'(p_z);
            yvz1_reg <= 48'(q_y) * 48'(p_z);
            zvy1_reg <= 48'(q_z) * 48'(p_y);
            zvx1_reg <= 48'(q_z) * 48'(p_x);
            xvz1_reg <= 48'(q_x) * 48'(p_z);
            xvy1_reg <= 48'(q_x) * 48'(p_y);
            yvx1_reg <= 48'(q_y) * 48'(p_x);
            w1_reg   <= q_w;
            x1_reg   <= q_x;
            y1_reg   <= q_y;
            z1_reg   <= q_z;
            px1_reg  <= p_x;
            py1_reg  <= p_y;
            pz1_reg  <= p_z;

            a2_reg   <= 34'(ww1_reg) - 34'(xx1_reg) - 34'(yy1_reg) - 34'(zz1_reg);
            n2_reg   <= DEN_W'(34'(ww1_reg) + 34'(xx1_reg) + 34'(yy1_reg) + 34'(zz1_reg));
            d2_reg   <= (51'(xv1_reg) + 51'(yv1_reg) + 51'(zv1_reg)) <<< 1;
            cx2_reg  <= 49'(yvz1_reg) - 49'(zvy1_reg);
            cy2_reg  <= 49'(zvx1_reg) - 49'(xvz1_reg);
            cz2_reg  <= 49'(xvy1_reg) - 49'(yvx1_reg);
            w2_reg   <= 17'(w1_reg) <<< 1;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            pz2_reg  <= pz1_reg;

            n3_reg     <= n2_reg;
            av3_reg[0] <= NUM_W'(a2_reg) * NUM_W'(px2_reg);
            av3_reg[1] <= NUM_W'(a2_reg) * NUM_W'(py2_reg);
            av3_reg[2] <= NUM_W'(a2_reg) * NUM_W'(pz2_reg);
            du3_reg[0] <= NUM_W'(d2_reg) * NUM_W'(x2_reg);
            du3_reg[1] <= NUM_W'(d2_reg) * NUM_W'(y2_reg);
            du3_reg[2] <= NUM_W'(d2_reg) * NUM_W'(z2_reg);
            wc3_reg[0] <= NUM_W'(w2_reg) * NUM_W'(cx2_reg);
            wc3_reg[1] <= NUM_W'(w2_reg) * NUM_W'(cy2_reg);
            wc3_reg[2] <= NUM_W'(w2_reg) * NUM_W'(cz2_reg);

            n4_reg <= n3_reg;
            for (int l = 0; l < LANES; l++)
            begin
                num4_reg[l] <= av3_reg[l] + du3_reg[l] + wc3_reg[l];
            end
        end
    end

    qpr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_ctl  (ctl4_reg),
        .num     (num4_reg),
        .den     (n4_reg),
        .out_ctl (out_ctl),
        .rot     (rot),
        .sat     (sat)
    );

    assign m_tvalid = out_ctl.valid;
    assign m_tdata  = {rot[2], rot[1], rot[0]};
    assign m_tuser  = {sat, out_ctl.zero};

    // a zero quaternion gives zero coordinates and no clipping
    `QPR_CHECK(a_zero_out, m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1], "zero quaternion result not cleared")
    // clipping leaves at least one coordinate on a rail
    `QPR_CHECK(a_sat_rail, m_tvalid && m_tuser[1] |-> rot[0] == POS_RAIL || rot[0] == NEG_RAIL || rot[1] == POS_RAIL || rot[1] == NEG_RAIL || rot[2] == POS_RAIL || rot[2] == NEG_RAIL, "saturated without a rail value")
    // a held pipeline keeps the norm and control of its numerator stage
    `QPR_CHECK(a_hold_num, !adv |=> $stable(n4_reg) && $stable(ctl4_reg), "numerator stage moved during stall")

endmodule

`default_nettype wire

/* rtl/qpr_div.sv */
// ----------------------------------------------------------------------------
// qpr_div
// pipelined rounded, saturating divide of three numerators by one norm
// ----------------------------------------------------------------------------
`default_nettype none

module qpr_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire qpr_pkg::qpr_ctl_t in_ctl,
    input  wire qpr_pkg::num_t     num [qpr_pkg::LANES],
    input  wire qpr_pkg::den_t     den,
    output qpr_pkg::qpr_ctl_t      out_ctl,
    output qpr_pkg::coord_t        rot [qpr_pkg::LANES],
    output logic                   sat
);
    import qpr_pkg::*;

    // stage 0 is the prepared operand, stages 1..DIV_STEPS the bit steps
    qpr_ctl_t          ctl_reg [DIV_STEPS+1];
    den_t              den_reg [DIV_STEPS+1];
    logic [DEN_W-1:0]  rem_reg [DIV_STEPS+1][LANES];
    logic [CW-1:0]     lo_reg  [DIV_STEPS+1][LANES];
    logic              neg_reg [DIV_STEPS+1][LANES];
    logic              ovf_reg [DIV_STEPS+1][LANES];

    logic [DEN_W-1:0]  rem_next [DIV_STEPS+1][LANES];
    logic [CW-1:0]     lo_next  [DIV_STEPS+1][LANES];
    logic              neg_next [LANES];
    logic              ovf_next [LANES];

    coord_t            rot_reg  [LANES];
    coord_t            rot_next [LANES];
    logic              sat_reg, sat_next;
    qpr_ctl_t          out_ctl_reg;

    // operand preparation: magnitude, overflow test, leading remainder
    // then one restoring step per stage, quotient bits shift into lo
    always_comb
    begin
        logic [NUM_W-1:0] mag;
        logic [DEN_W:0]   t;
        logic             ge;
        for (int l = 0; l < LANES; l++)
        begin
            mag = num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
            neg_next[l]    = num[l][NUM_W-1];
            // quotient of 2^32 or more always saturates
            ovf_next[l]    = mag >= {(NUM_W-DEN_W-CW)'(0), den, CW'(0)};
            rem_next[0][l] = mag[CW+DEN_W-1:CW];
            lo_next[0][l]  = mag[CW-1:0];
        end
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                t  = {rem_reg[k-1][l], lo_reg[k-1][l][CW-1]};
                ge = t >= {1'b0, den_reg[k-1]};
                rem_next[k][l] = ge ? DEN_W'(t - {1'b0, den_reg[k-1]}) : t[DEN_W-1:0];
                lo_next[k][l]  = {lo_reg[k-1][l][CW-2:0], ge};
            end
        end
    end

    // round half away from zero, then clip
    always_comb
    begin
        logic          rnd;
        logic [CW:0]   qr;
        logic          clip;
        sat_next = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            rnd  = {rem_reg[DIV_STEPS][l], 1'b0} >= {1'b0, den_reg[DIV_STEPS]};
            qr   = {1'b0, lo_reg[DIV_STEPS][l]} + (CW+1)'(rnd);
            if (neg_reg[DIV_STEPS][l])
            begin
                clip        = ovf_reg[DIV_STEPS][l] || (qr > {1'b0, NEG_RAIL});
                rot_next[l] = clip ? NEG_RAIL : CW'(-qr);
            end
            else
            begin
                clip        = ovf_reg[DIV_STEPS][l] || (qr > {1'b0, POS_RAIL});
                rot_next[l] = clip ? POS_RAIL : qr[CW-1:0];
            end
            if (ctl_reg[DIV_STEPS].zero)
            begin
                clip        = 1'b0;
                rot_next[l] = '0;
            end
            sat_next = sat_next | clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                ctl_reg[k] <= '0;
            end
            out_ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= in_ctl;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
            out_ctl_reg <= ctl_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= rem_next[0][l];
                lo_reg[0][l]  <= lo_next[0][l];
                neg_reg[0][l] <= neg_next[l];
                ovf_reg[0][l] <= ovf_next[l];
            end
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                den_reg[k] <= den_reg[k-1];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    lo_reg[k][l]  <= lo_next[k][l];
                    neg_reg[k][l] <= neg_reg[k-1][l];
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                end
            end
            for (int l = 0; l < LANES; l++)
            begin
                rot_reg[l] <= rot_next[l];
            end
            sat_reg <= sat_next;
        end
    end

    assign out_ctl = out_ctl_reg;
    assign rot     = rot_reg;
    assign sat     = sat_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quaternion_point_rotation. It drives directed and
// random quaternion/point transfers and holds a scoreboard with its own
// exact-integer rotation predictor. Every output transfer is checked in
// order; in some phases the sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import qpr_pkg::*;

    typedef logic signed [159:0] acc_t;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        logic signed [31:0] px, py, pz;
    } rot_req_t;

    typedef struct {
        logic signed [31:0] rx, ry, rz;
        logic               zero_quat;
        logic               saturated;
    } rot_res_t;

    // rotation scoreboard: predicts q v conj(q) / |q|^2 and checks outputs in order
    class rotation_scoreboard;
        rot_res_t pending[$];
        int       errors = 0;
        int       checked = 0;

        function automatic rot_res_t rotate(rot_req_t r);
            longint   w, x, y, z, uu, n, a, d2, w2;
            longint   v[3], u[3], c[3];
            acc_t     num;
            logic [159:0] mag, quo, rem, den;
            logic [31:0]  coord[3];
            rot_res_t res;
            w = r.w; x = r.x; y = r.y; z = r.z;
            v[0] = r.px; v[1] = r.py; v[2] = r.pz;
            u[0] = x; u[1] = y; u[2] = z;
            uu = x * x + y * y + z * z;
            n = w * w + uu;
            res.saturated = 1'b0;
            res.zero_quat = 1'b0;
            if (n == 0) begin
                res.rx = '0; res.ry = '0; res.rz = '0;
                res.zero_quat = 1'b1;
                return res;
            end
            a = w * w - uu;
            d2 = 2 * (x * v[0] + y * v[1] + z * v[2]);
            w2 = 2 * w;
            c[0] = y * v[2] - z * v[1];
            c[1] = z * v[0] - x * v[2];
            c[2] = x * v[1] - y * v[0];
            den = 160'(n);
            for (int i = 0; i < 3; i++) begin
                num = acc_t'(a) * acc_t'(v[i]) + acc_t'(d2) * acc_t'(u[i])
                    + acc_t'(w2) * acc_t'(c[i]);
                mag = (num < 0) ? -num : num;
                quo = mag / den;
                rem = mag % den;
                // round half away from zero
                if (2 * rem >= den)
                    quo = quo + 1;
                if (num < 0) begin
                    if (quo > 160'h8000_0000) begin
                        coord[i] = NEG_RAIL;
                        res.saturated = 1'b1;
                    end
                    else
                        coord[i] = -quo[31:0];
                end
                else begin
                    if (quo > 160'h7FFF_FFFF) begin
                        coord[i] = POS_RAIL;
                        res.saturated = 1'b1;
                    end
                    else
                        coord[i] = quo[31:0];
                end
            end
            res.rx = coord[0]; res.ry = coord[1]; res.rz = coord[2];
            return res;
        endfunction

        function void note_input(rot_req_t r);
            pending.push_back(rotate(r));
        endfunction

        function void check_result(rot_res_t got);
            rot_res_t exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got.rx !== exp_r.rx) begin
                $error("rot_x expected %0d got %0d", exp_r.rx, got.rx); errors++;
            end
            if (got.ry !== exp_r.ry) begin
                $error("rot_y expected %0d got %0d", exp_r.ry, got.ry); errors++;
            end
            if (got.rz !== exp_r.rz) begin
                $error("rot_z expected %0d got %0d", exp_r.rz, got.rz); errors++;
            end
            if (got.zero_quat !== exp_r.zero_quat) begin
                $error("zero_quat expected %0b got %0b", exp_r.zero_quat, got.zero_quat);
                errors++;
            end
            if (got.saturated !== exp_r.saturated) begin
                $error("saturated expected %0b got %0b", exp_r.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    rotation_scoreboard rot_sb = new();
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  sent = 0;
    int  sat_seen = 0;
    int  zero_seen = 0;
    longint cycles = 0;

    localparam longint CYCLE_LIMIT = 400000;

    quaternion_point_rotation uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // input and output transfer monitors
    always @(posedge clk)
    begin
        rot_req_t r;
        rot_res_t g;
        if (rst_n && s_tvalid && s_tready) begin
            r.w = s_tdata[15:0];    r.x = s_tdata[31:16];
            r.y = s_tdata[47:32];   r.z = s_tdata[63:48];
            r.px = s_tdata[95:64];  r.py = s_tdata[127:96];
            r.pz = s_tdata[159:128];
            rot_sb.note_input(r);
        end
        if (rst_n && m_tvalid && m_tready) begin
            g.rx = m_tdata[31:0];
            g.ry = m_tdata[63:32];
            g.rz = m_tdata[95:64];
            g.zero_quat = m_tuser[0];
            g.saturated = m_tuser[1];
            if (g.zero_quat) zero_seen++;
            if (g.saturated) sat_seen++;
            rot_sb.check_result(g);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_rotation(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                                 logic [15:0] z, logic [31:0] px, logic [31:0] py,
                                 logic [31:0] pz);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px, z, y, x, w};
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    task automatic send_random;
        logic [15:0] q[4];
        logic [31:0] p[3];
        int          kind;
        kind = $urandom_range(99);
        for (int i = 0; i < 4; i++)
            q[i] = 16'($urandom);
        for (int i = 0; i < 3; i++)
            p[i] = $urandom;
        if (kind < 2) begin
            q[0] = '0; q[1] = '0; q[2] = '0; q[3] = '0;
        end
        else if (kind < 15) begin
            // tiny quaternions, coarse rounding of the norm
            for (int i = 0; i < 4; i++)
                q[i] = $signed(4'($urandom));
        end
        else if (kind < 30) begin
            // one component set near unit, the others left random, with short points
            q[$urandom_range(3)] = 16'sd16384 + $signed(6'($urandom));
            for (int i = 0; i < 3; i++)
                p[i] = $signed(20'($urandom));
        end
        send_rotation(q[0], q[1], q[2], q[3], p[0], p[1], p[2]);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (rot_sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: identity, extremes, zero, axis turns
        send_rotation(16'sd16384, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_rotation(16'sh8000, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_rotation(0, 0, 0, 0, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
        send_rotation(0, 16'sh8000, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_rotation(0, 0, 16'sh7FFF, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_rotation(0, 0, 0, 16'sh8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_rotation(16'sd11585, 0, 0, 16'sd11585, 32'h0001_0000, 0, 0);
        send_rotation(16'sd11585, 16'sd11585, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_rotation(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_rotation(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // rotate the long diagonal onto an axis to force clipping
        send_rotation(16'sd14000, 16'sd6000, -16'sd6000, 0,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_rotation(16'sd14000, -16'sd6000, 16'sd6000, 0,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_rotation(1, 1, 0, 0, 32'h0000_0001, 32'h0000_0003, 32'hFFFF_FFFF);
        send_rotation(1, 1, 1, 1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002);
        send_rotation(-16'sd1, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_0001, 0);
        send_rotation(0, 0, 0, 16'sd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555);
        send_rotation(16'sd3, 16'sd2, 0, 0, 32'h0000_0005, 32'h0000_0007, 32'h0000_000B);
        send_rotation(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        drain();

        // phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 10 : 0;
            stall_pct = (ph == 2) ? 49 : (ph == 3) ? 10 : 0;
            for (int i = 0; i < 460; i++) begin
                send_random();
                // stretches with no idling or stalling inside a phase
                if (i == 200) begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                if (i == 260) begin
                    idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 10 : 0;
                    stall_pct = (ph == 2) ? 49 : (ph == 3) ? 10 : 0;
                end
            end
            drain();
        end

        s_tvalid <= 1'b0;
        stall_pct = 0;
        while (rot_sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("sent %0d rotations, checked %0d results", sent, rot_sb.checked);
        $display("zero quaternions seen %0d, clipped results seen %0d", zero_seen, sat_seen);
        if (rot_sb.errors == 0 && rot_sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
